// File: src/three_phase_led_sequencer_assert.svh
`ifndef THREE_PHASE_LED_SEQUENCER_ASSERT_SVH
`define THREE_PHASE_LED_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TPLS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TPLS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tpls_pkg.sv
package tpls_pkg;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned BEAT_W   = 7;
   localparam int unsigned STEP_W   = 6;
   localparam int unsigned PHASE_W  = 2;
   localparam int unsigned LINE_W   = 4;

   localparam logic [BEAT_W-1:0]   BEAT_LIMIT    = 7'd64;
   localparam logic [STEP_W-1:0]   PERIOD_RESET  = 6'd16;
   localparam logic [SAMPLE_W:0]   PERIOD_MIN    = 9'd2;
   localparam logic [SAMPLE_W:0]   SAMPLE_SPAN   = 9'd256;
   localparam logic [SAMPLE_W-1:0] FWD_THRESHOLD = 8'd127;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_ONE   = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TWO   = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_THREE = 2'd3;

   localparam logic [LINE_W-1:0] LINE_A_MASK  = 4'b0001;
   localparam logic [LINE_W-1:0] LINE_B_MASK  = 4'b0010;
   localparam logic [LINE_W-1:0] LINE_C_MASK  = 4'b0100;
   localparam logic [LINE_W-1:0] LINE_HB_MASK = 4'b1000;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
   } req_word_type;

   typedef struct packed {
      logic phase_a;
      logic phase_b;
      logic phase_c;
      logic heartbeat;
      logic adc_start;
   } rsp_word_type;

endpackage

// File: src/tpls_state.sv
module tpls_state
   import tpls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   logic [STEP_W-1:0]  step_count_ff,  step_count_in;
   logic [BEAT_W-1:0]  beat_count_ff,  beat_count_in;
   logic [STEP_W-1:0]  step_period_ff, step_period_in;
   logic               reverse_ff,     reverse_in;
   logic [PHASE_W-1:0] phase_ff,       phase_in;
   logic [LINE_W-1:0]  lines_ff,       lines_in;

   always_comb begin
      logic [LINE_W-1:0]   lead_mask;
      logic [LINE_W-1:0]   trail_mask;
      logic [STEP_W-1:0]   step_mid;
      logic [STEP_W-1:0]   step_inc;
      logic [BEAT_W-1:0]   beat_mid;
      logic                start;
      logic                sample_fwd;
      logic [SAMPLE_W:0]   span_left;
      logic [SAMPLE_W:0]   period_raw;

      step_count_in  = step_count_ff;
      beat_count_in  = beat_count_ff;
      step_period_in = step_period_ff;
      reverse_in     = reverse_ff;
      phase_in       = phase_ff;
      lines_in       = lines_ff;
      start          = 1'b0;
      lead_mask      = reverse_ff ? LINE_B_MASK : LINE_C_MASK;
      trail_mask     = reverse_ff ? LINE_C_MASK : LINE_B_MASK;
      step_mid       = step_count_ff;
      step_inc       = '0;
      beat_mid       = beat_count_ff;
      sample_fwd     = req_word.sample > FWD_THRESHOLD;
      span_left      = SAMPLE_SPAN - {1'b0, req_word.sample};
      period_raw     = '0;

      if (req_word.kind == KIND_TICK) begin
         if (beat_count_ff == BEAT_LIMIT) begin
            lines_in = lines_in ^ LINE_HB_MASK;
            beat_mid = '0;
            start    = 1'b1;
         end
         if (step_count_ff == step_period_ff) begin
            case (phase_ff)
               PHASE_IDLE: begin
                  lines_in = lines_in ^ lead_mask;
                  phase_in = PHASE_ONE;
               end
               PHASE_ONE: begin
                  lines_in = lines_in ^ (lead_mask | LINE_A_MASK);
                  phase_in = PHASE_TWO;
               end
               PHASE_TWO: begin
                  lines_in = lines_in ^ (LINE_A_MASK | trail_mask);
                  phase_in = PHASE_THREE;
               end
               default: begin
                  lines_in = lines_in ^ (lead_mask | trail_mask);
                  phase_in = PHASE_ONE;
               end
            endcase
            step_mid = '0;
         end
         step_inc      = step_mid + STEP_W'(1);
         beat_count_in = beat_mid + BEAT_W'(1);
         step_count_in = (step_inc > step_period_ff) ? '0 : step_inc;
      end else begin
         period_raw = sample_fwd ? (span_left >> 2)
                                 : {1'b0, (req_word.sample >> 2)};
         if (period_raw < PERIOD_MIN) begin
            period_raw = PERIOD_MIN;
         end
         step_period_in = period_raw[STEP_W-1:0];
         if (reverse_ff == sample_fwd) begin
            lines_in = '0;
            phase_in = PHASE_IDLE;
         end
         reverse_in = ~sample_fwd;
      end

      rsp_word.phase_a   = lines_in[0];
      rsp_word.phase_b   = lines_in[1];
      rsp_word.phase_c   = lines_in[2];
      rsp_word.heartbeat = lines_in[3];
      rsp_word.adc_start = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff  <= '0;
         beat_count_ff  <= '0;
         step_period_ff <= PERIOD_RESET;
         reverse_ff     <= 1'b1;
         phase_ff       <= PHASE_IDLE;
         lines_ff       <= '0;
      end else if (step_en) begin
         step_count_ff  <= step_count_in;
         beat_count_ff  <= beat_count_in;
         step_period_ff <= step_period_in;
         reverse_ff     <= reverse_in;
         phase_ff       <= phase_in;
         lines_ff       <= lines_in;
      end
   end

endmodule

// File: src/three_phase_led_sequencer.sv
// Three-phase LED sequencer. Each accepted word is a timer tick or an 8-bit
// potentiometer sample and yields exactly one result word holding the phase
// lines, the heartbeat line and the conversion request. A word passes an
// input register, one update of the sequencer state and a result register,
// and one word is accepted every cycle while the result side is not stalled.
// The input register takes one more word while a finished result waits to be
// taken.
module three_phase_led_sequencer
   import tpls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_phase_a,
   output logic                rsp_phase_b,
   output logic                rsp_phase_c,
   output logic                rsp_heartbeat,
   output logic                rsp_adc_start
);

   logic         in_valid_ff,  in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         out_free;
   logic         advance;
   logic         req_fire;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;
   assign req_fire  = req_valid & req_ready;

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   tpls_state u_state (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .req_word (in_word_ff),
      .rsp_word (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff.kind   <= req_type;
         in_word_ff.sample <= req_sample;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phase_a   = rsp_word_ff.phase_a;
   assign rsp_phase_b   = rsp_word_ff.phase_b;
   assign rsp_phase_c   = rsp_word_ff.phase_c;
   assign rsp_heartbeat = rsp_word_ff.heartbeat;
   assign rsp_adc_start = rsp_word_ff.adc_start;

endmodule

// File: src/tpls_checker.sv
`include "three_phase_led_sequencer_assert.svh"

module tpls_checker
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_phase_a,
   input logic rsp_phase_b,
   input logic rsp_phase_c,
   input logic rsp_heartbeat,
   input logic rsp_adc_start
);

   logic hb_last_ff, hb_last_in;

   // track the heartbeat level of the last delivered word
   assign hb_last_in = (rsp_valid & rsp_ready) ? rsp_heartbeat : hb_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_last_ff <= 1'b0;
      end else begin
         hb_last_ff <= hb_last_in;
      end
   end

   `TPLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_phase_a, rsp_phase_b, rsp_phase_c, rsp_heartbeat,
      rsp_adc_start}), "result word changed while stalled")
   `TPLS_ASSERT_NOW(a_req_to_rsp, clock, reset, req_valid && req_ready,
      ##2 rsp_valid, "accepted word produced no result")
   `TPLS_ASSERT_NOW(a_hb_toggle, clock, reset, rsp_valid && rsp_adc_start,
      rsp_heartbeat != hb_last_ff, "heartbeat did not toggle with request")
   `TPLS_ASSERT_NOW(a_hb_rise, clock, reset, rsp_valid && !rsp_adc_start,
      !rsp_heartbeat || hb_last_ff, "heartbeat rose without request")

endmodule

bind three_phase_led_sequencer tpls_checker u_tpls_checker (.*);
